### sv/pid_aw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_aw_pkg
// Shared widths, register indexes, state codes and payload types of the
// PID step block with integral anti-windup.
// ----------------------------------------------------------------------------
package pid_aw_pkg;

  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned FRAC_BITS    = 8;
  localparam int unsigned GAIN_W       = 16;
  localparam int unsigned DT_W         = 24;
  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned CFG_DATA_W   = (SAMPLE_WIDTH > GAIN_W) ? SAMPLE_WIDTH : GAIN_W;

  // microseconds per second, the time base of the integral and derivative terms
  localparam int unsigned US_W = 20;
  localparam logic [US_W-1:0] US_PER_S = US_W'(1000000);

  localparam logic signed [SAMPLE_WIDTH-1:0] OUT_HIGH_RST = SAMPLE_WIDTH'(25600);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SETPOINT = 3'd0,
    CFG_GAIN_P   = 3'd1,
    CFG_GAIN_I   = 3'd2,
    CFG_GAIN_D   = 3'd3,
    CFG_OUT_LOW  = 3'd4,
    CFG_OUT_HIGH = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ARM,
    ST_MUL1_GO,
    ST_MUL1,
    ST_ISUM,
    ST_ICLAMP,
    ST_MUL2_GO,
    ST_MUL2,
    ST_DIV_GO,
    ST_DIV,
    ST_SIGN,
    ST_SUM,
    ST_DRIVE
  } pid_state_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] measurement;
    logic [DT_W-1:0]                elapsed_us;
  } pid_in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] drive;
    logic                           armed_now;
  } pid_out_t;

endpackage
`default_nettype wire

### sv/pid_aw_smul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_aw_smul
// Bit-serial multiplier: signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module pid_aw_smul
  import pid_aw_pkg::*;
#(
  parameter int unsigned A_W = SAMPLE_WIDTH + 1,
  parameter int unsigned B_W = GAIN_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [A_W-1:0]       a,
  input  logic [B_W-1:0]              b,
  output logic                        busy,
  output logic signed [A_W+B_W-1:0]   prod
);

  localparam int unsigned CNT_W = $clog2(B_W + 1);

  logic                  busy_r, busy_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic signed [A_W-1:0] a_r;
  logic signed [A_W:0]   hi_r, hi_nxt, addend, psum;
  logic [B_W-1:0]        lo_r, lo_nxt;

  // upper half accumulates, lower half shifts out multiplier bits and takes product bits
  assign addend  = lo_r[0] ? {a_r[A_W-1], a_r} : '0;
  assign psum    = hi_r + addend;
  assign hi_nxt  = {psum[A_W], psum[A_W:1]};
  assign lo_nxt  = {psum[0], lo_r[B_W-1:1]};
  assign cnt_nxt = cnt_r - 1'b1;
  assign busy_nxt = (cnt_r != CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(B_W);
    end else if (busy_r) begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign busy = busy_r;
  assign prod = {hi_r[A_W-1:0], lo_r};

endmodule
`default_nettype wire

### sv/pid_aw_sdiv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_aw_sdiv
// Restoring divider for unsigned operands, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pid_aw_sdiv
  import pid_aw_pkg::*;
#(
  parameter int unsigned N_W = 2 * SAMPLE_WIDTH + US_W,
  parameter int unsigned M_W = DT_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [M_W-1:0] divisor,
  output logic           busy,
  output logic [N_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(N_W + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [N_W-1:0]   q_r, q_nxt;
  logic [M_W-1:0]   rem_r, rem_nxt, dvs_r;
  logic [M_W:0]     trial, diff;
  logic             ge;

  // dividend bits leave the top of q_r while quotient bits enter at the bottom
  assign trial    = {rem_r, q_r[N_W-1]};
  assign ge       = (trial >= {1'b0, dvs_r});
  assign diff     = trial - {1'b0, dvs_r};
  assign rem_nxt  = ge ? diff[M_W-1:0] : trial[M_W-1:0];
  assign q_nxt    = {q_r[N_W-2:0], ge};
  assign cnt_nxt  = cnt_r - 1'b1;
  assign busy_nxt = (cnt_r != CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(N_W);
    end else if (busy_r) begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

### sv/pid_step_with_antiwindup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_step_with_antiwindup
// PID temperature step in fixed point with a clamped integral, built from
// bit-serial multipliers and restoring dividers under one sequencer.
// ----------------------------------------------------------------------------
//  port group  direction  handshake             payload
//  in_*        request    in_valid / in_ready   pid_in_t  (measurement, elapsed_us)
//  out_*       result     out_valid / out_ready pid_out_t (drive, armed_now)
//  cfg_*       config     cfg_we                cfg_addr, cfg_wdata
//
//  first request after reset only arms the loop
//  later requests run to the next accept through the chain of the
//  err*dt multiply (24 steps), gain/1e6 multiplies (20 steps) and the
//  54-step quotient of the derivative term
//  a stalled result holds in the output register; a new request is taken
//  as soon as the result is loaded, so only a second result waits on out_ready
//  rst_n is synchronous; config, integral, last error and armed flag reset
// ----------------------------------------------------------------------------
module pid_step_with_antiwindup
  import pid_aw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pid_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pid_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned SW     = SAMPLE_WIDTH;
  localparam int unsigned ERR_W  = SW + 1;
  localparam int unsigned DERR_W = SW + 2;
  localparam int unsigned ED_W   = ERR_W + DT_W;
  localparam int unsigned ACC_W  = SW + US_W;
  localparam int unsigned ISUM_W = ED_W + 1;
  localparam int unsigned P_W    = ERR_W + GAIN_W;
  localparam int unsigned GI_W   = ACC_W + GAIN_W;
  localparam int unsigned GD_W   = DERR_W + GAIN_W;
  localparam int unsigned NUM_W  = GD_W + US_W;
  localparam int unsigned SUM_W  = NUM_W + 1;
  localparam logic signed [US_W:0] US_PER_S_S = {1'b0, US_PER_S};

  // configuration
  logic signed [SW-1:0] setpoint_r, out_low_r, out_high_r;
  logic [GAIN_W-1:0]    gain_p_r, gain_i_r, gain_d_r;

  // sequencer
  pid_state_t state_r, state_nxt;
  logic       take, arm_load, out_load, start_m1, start_m2, start_dv;
  logic       isum_en, acc_en, sign_en, sum_en, out_free;

  // loop state
  logic                    started_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ERR_W-1:0] last_err_r;

  // datapath
  logic signed [ERR_W-1:0]  err_r, err_nxt;
  logic [DT_W-1:0]          dt_r;
  logic signed [DERR_W-1:0] derr;
  logic signed [ACC_W:0]    hi_full, lo_full;
  logic signed [ACC_W-1:0]  lim_hi_r, lim_lo_r;
  logic signed [ISUM_W-1:0] isum_r, isum_nxt, ilim_hi, ilim_lo;
  logic signed [ED_W-1:0]   ed_prod;
  logic signed [P_W-1:0]    p_prod;
  logic signed [GD_W-1:0]   gd_prod;
  logic signed [GI_W-1:0]   gi_prod;
  logic signed [NUM_W-1:0]  num_prod;
  logic [GI_W-1:0]          gi_mag, iq;
  logic [NUM_W-1:0]         num_mag, dq;
  logic                     gi_neg_r, num_neg_r;
  logic signed [SUM_W-1:0]  p_ext, iq_ext, dq_ext;
  logic signed [SUM_W-1:0]  pi_r, pi_nxt, d_r, d_nxt, sum_r, sum_nxt;
  logic signed [SUM_W-1:0]  shifted, out_hi_ext, out_lo_ext;
  logic signed [SW-1:0]     drive_clamp;
  logic signed [SW-1:0]     out_drive_r, out_drive_nxt;
  logic                     out_armed_r, out_valid_r, out_valid_nxt;
  logic ed_busy, gp_busy, gd_busy, gi_busy, us_busy, iq_busy, dq_busy;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= '0;
      gain_p_r   <= '0;
      gain_i_r   <= '0;
      gain_d_r   <= '0;
      out_low_r  <= '0;
      out_high_r <= OUT_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SETPOINT: setpoint_r <= SW'(cfg_wdata);
        CFG_GAIN_P:   gain_p_r   <= GAIN_W'(cfg_wdata);
        CFG_GAIN_I:   gain_i_r   <= GAIN_W'(cfg_wdata);
        CFG_GAIN_D:   gain_d_r   <= GAIN_W'(cfg_wdata);
        CFG_OUT_LOW:  out_low_r  <= SW'(cfg_wdata);
        CFG_OUT_HIGH: out_high_r <= SW'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // integral limits scaled to degree-microseconds
  assign hi_full = out_high_r * US_PER_S_S;
  assign lo_full = out_low_r * US_PER_S_S;

  // ---------------------------------------------------------------- sequencer
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    take      = 1'b0;
    arm_load  = 1'b0;
    out_load  = 1'b0;
    start_m1  = 1'b0;
    start_m2  = 1'b0;
    start_dv  = 1'b0;
    isum_en   = 1'b0;
    acc_en    = 1'b0;
    sign_en   = 1'b0;
    sum_en    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          take      = 1'b1;
          state_nxt = started_r ? ST_MUL1_GO : ST_ARM;
        end
      end
      ST_ARM: begin
        if (out_free) begin
          out_load  = 1'b1;
          arm_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL1_GO: begin
        start_m1  = 1'b1;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        if (!(ed_busy || gp_busy || gd_busy)) state_nxt = ST_ISUM;
      end
      ST_ISUM: begin
        isum_en   = 1'b1;
        state_nxt = ST_ICLAMP;
      end
      ST_ICLAMP: begin
        acc_en    = 1'b1;
        state_nxt = ST_MUL2_GO;
      end
      ST_MUL2_GO: begin
        start_m2  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        if (!(gi_busy || us_busy)) state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        start_dv  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!(iq_busy || dq_busy)) state_nxt = ST_SIGN;
      end
      ST_SIGN: begin
        sign_en   = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        sum_en    = 1'b1;
        state_nxt = ST_DRIVE;
      end
      ST_DRIVE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  assign err_nxt = ERR_W'(setpoint_r) - ERR_W'(in_data.measurement);
  assign derr    = DERR_W'(err_r) - DERR_W'(last_err_r);

  // integral update: upper bound first, so crossed limits end on the lower one
  assign isum_nxt = ISUM_W'(acc_r) + ISUM_W'(ed_prod);
  assign ilim_hi  = ISUM_W'(lim_hi_r);
  assign ilim_lo  = ISUM_W'(lim_lo_r);

  always_comb begin
    if (isum_r > ilim_hi) begin
      acc_nxt = (lim_hi_r < lim_lo_r) ? lim_lo_r : lim_hi_r;
    end else if (isum_r < ilim_lo) begin
      acc_nxt = lim_lo_r;
    end else begin
      acc_nxt = isum_r[ACC_W-1:0];
    end
  end

  assign gi_mag  = gi_prod[GI_W-1] ? GI_W'(-gi_prod) : GI_W'(gi_prod);
  assign num_mag = num_prod[NUM_W-1] ? NUM_W'(-num_prod) : NUM_W'(num_prod);

  // quotients come back as magnitudes; restoring the sign truncates toward zero
  assign p_ext  = SUM_W'(p_prod);
  assign iq_ext = SUM_W'(iq);
  assign dq_ext = SUM_W'(dq);
  assign pi_nxt = gi_neg_r ? (p_ext - iq_ext) : (p_ext + iq_ext);
  assign d_nxt  = (dt_r == '0) ? '0 : (num_neg_r ? -dq_ext : dq_ext);
  assign sum_nxt = pi_r + d_r;

  // arithmetic shift floors the Q16 sum back to Q8
  assign shifted    = sum_r >>> FRAC_BITS;
  assign out_hi_ext = SUM_W'(out_high_r);
  assign out_lo_ext = SUM_W'(out_low_r);

  always_comb begin
    if (shifted > out_hi_ext) begin
      drive_clamp = (out_high_r < out_low_r) ? out_low_r : out_high_r;
    end else if (shifted < out_lo_ext) begin
      drive_clamp = out_low_r;
    end else begin
      drive_clamp = shifted[SW-1:0];
    end
  end

  assign out_drive_nxt = arm_load ? '0 : drive_clamp;
  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // ---------------------------------------------------------------- serial units
  pid_aw_smul #(.A_W(ERR_W), .B_W(DT_W)) u_ed (
    .clk(clk), .rst_n(rst_n), .start(start_m1),
    .a(err_r), .b(dt_r), .busy(ed_busy), .prod(ed_prod)
  );

  pid_aw_smul #(.A_W(ERR_W), .B_W(GAIN_W)) u_gp (
    .clk(clk), .rst_n(rst_n), .start(start_m1),
    .a(err_r), .b(gain_p_r), .busy(gp_busy), .prod(p_prod)
  );

  pid_aw_smul #(.A_W(DERR_W), .B_W(GAIN_W)) u_gd (
    .clk(clk), .rst_n(rst_n), .start(start_m1),
    .a(derr), .b(gain_d_r), .busy(gd_busy), .prod(gd_prod)
  );

  pid_aw_smul #(.A_W(ACC_W), .B_W(GAIN_W)) u_gi (
    .clk(clk), .rst_n(rst_n), .start(start_m2),
    .a(acc_r), .b(gain_i_r), .busy(gi_busy), .prod(gi_prod)
  );

  pid_aw_smul #(.A_W(GD_W), .B_W(US_W)) u_us (
    .clk(clk), .rst_n(rst_n), .start(start_m2),
    .a(gd_prod), .b(US_PER_S), .busy(us_busy), .prod(num_prod)
  );

  pid_aw_sdiv #(.N_W(GI_W), .M_W(US_W)) u_iq (
    .clk(clk), .rst_n(rst_n), .start(start_dv),
    .dividend(gi_mag), .divisor(US_PER_S), .busy(iq_busy), .quotient(iq)
  );

  // a zero dt divides to garbage here; the derivative is forced to zero after
  pid_aw_sdiv #(.N_W(NUM_W), .M_W(DT_W)) u_dq (
    .clk(clk), .rst_n(rst_n), .start(start_dv),
    .dividend(num_mag), .divisor(dt_r), .busy(dq_busy), .quotient(dq)
  );

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      acc_r       <= '0;
      last_err_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (arm_load) started_r <= 1'b1;
      if (acc_en) acc_r <= acc_nxt;
      if (start_m1) last_err_r <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    lim_hi_r <= hi_full[ACC_W-1:0];
    lim_lo_r <= lo_full[ACC_W-1:0];
    if (take) begin
      err_r <= err_nxt;
      dt_r  <= in_data.elapsed_us;
    end
    if (isum_en) isum_r <= isum_nxt;
    if (start_dv) begin
      gi_neg_r  <= gi_prod[GI_W-1];
      num_neg_r <= num_prod[NUM_W-1];
    end
    if (sign_en) begin
      pi_r <= pi_nxt;
      d_r  <= d_nxt;
    end
    if (sum_en) sum_r <= sum_nxt;
    if (out_load) begin
      out_drive_r <= out_drive_nxt;
      out_armed_r <= arm_load;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = '{drive: out_drive_r, armed_now: out_armed_r};

  // ---------------------------------------------------------------- checks
  a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |->
      !(ed_busy || gp_busy || gd_busy || gi_busy || us_busy || iq_busy || dq_busy))
    else $error("serial unit still running while sequencer is idle");

  a_arm_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(started_r) |-> (out_valid_r && out_armed_r))
    else $error("loop armed without an armed result");

  a_started_hold: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("armed flag dropped outside reset");

  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_ARM || $past(state_r) == ST_DRIVE))
    else $error("result loaded outside the arm or drive step");

endmodule
`default_nettype wire
